FILE: hw/rtl/kmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_pkg: shared types and constants for the keypad majority debounce
// Key index encoding, window defaults, threshold reset and the character map.
// ----------------------------------------------------------------------------
package kmd_pkg;

  localparam int unsigned KEY_W          = 5;
  localparam int unsigned KEY_BINS       = 17;
  localparam int unsigned MATRIX_W       = 16;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned THRESH_W       = 3;
  localparam int unsigned WINDOW_LEN_DEF = 6;

  localparam logic [KEY_W-1:0]    NO_KEY     = 5'd16;
  localparam logic [THRESH_W-1:0] THRESH_RST = 3'd4;

  // Item handed from the sample stage to the vote stages
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] raw;
  } kmd_s1_t;

  // Fixed keypad legend, row-major
  function automatic logic [CHAR_W-1:0] key_legend_f(input logic [KEY_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    ch = 7'h4E;                  // 'N'
    unique case (idx)
      5'd0:    ch = 7'h31;       // '1'
      5'd1:    ch = 7'h32;       // '2'
      5'd2:    ch = 7'h33;       // '3'
      5'd3:    ch = 7'h6E;       // 'n'
      5'd4:    ch = 7'h34;       // '4'
      5'd5:    ch = 7'h35;       // '5'
      5'd6:    ch = 7'h36;       // '6'
      5'd7:    ch = 7'h46;       // 'F'
      5'd8:    ch = 7'h37;       // '7'
      5'd9:    ch = 7'h38;       // '8'
      5'd10:   ch = 7'h39;       // '9'
      5'd11:   ch = 7'h6E;       // 'n'
      5'd12:   ch = 7'h2A;       // '*'
      5'd13:   ch = 7'h30;       // '0'
      5'd14:   ch = 7'h23;       // '#'
      5'd15:   ch = 7'h52;       // 'R'
      default: ch = 7'h4E;       // 'N'
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/kmd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_in_if: scan snapshot channel
// Valid/ready channel carrying one 4x4 key matrix snapshot per item.
// ----------------------------------------------------------------------------
interface kmd_in_if
  import kmd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [MATRIX_W-1:0] key_matrix;

  modport source (output valid, output key_matrix, input ready);
  modport sink   (input valid, input key_matrix, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/kmd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_out_if: debounce result channel
// Valid/ready channel carrying raw index, debounced index and its character.
// ----------------------------------------------------------------------------
interface kmd_out_if
  import kmd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  raw_index;
  logic [KEY_W-1:0]  key_index;
  logic [CHAR_W-1:0] key_ascii;

  modport source (output valid, output raw_index, output key_index, output key_ascii,
                  input ready);
  modport sink   (input valid, input raw_index, input key_index, input key_ascii,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/kmd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_cell: one slot of the sample window
// Holds one raw index and passes it to the next slot on every accepted item.
// ----------------------------------------------------------------------------
module kmd_cell
  import kmd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_i,
  input  wire logic [KEY_W-1:0] sample_i,
  output logic      [KEY_W-1:0] sample_o
);

  logic [KEY_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= NO_KEY;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule
`default_nettype wire

FILE: hw/rtl/kmd_vote.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_vote: majority vote and report stages
// Two-level argmax over the histogram, threshold check, repeat suppression.
// ----------------------------------------------------------------------------
module kmd_vote
  import kmd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kmd_s1_t             s1_i,
  output logic                     s1_ready_o,
  input  wire logic [$clog2(WINDOW_LEN+1)-1:0] hist_i [KEY_BINS],
  input  wire logic [THRESH_W-1:0] thresh_i,
  kmd_out_if.source                res_out
);

  localparam int unsigned CntW   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CmpW   = (CntW > THRESH_W) ? CntW : THRESH_W;
  localparam int unsigned Groups = 4;

  // group stage
  logic                s2_valid_q;
  logic [KEY_W-1:0]    s2_raw_q;
  logic [KEY_W-1:0]    grp_idx_q [Groups];
  logic [CntW-1:0]     grp_cnt_q [Groups];
  logic [CntW-1:0]     nk_cnt_q;
  logic [KEY_W-1:0]    grp_idx_d [Groups];
  logic [CntW-1:0]     grp_cnt_d [Groups];

  // output stage
  logic                out_valid_q;
  logic [KEY_W-1:0]    out_raw_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic [KEY_W-1:0]    last_q;

  logic                out_free;
  logic                s1_take;
  logic                s2_adv;
  logic [KEY_W-1:0]    best_idx;
  logic [CntW-1:0]     best_cnt;
  logic                hit;
  logic [KEY_W-1:0]    report;

  assign out_free   = !out_valid_q || res_out.ready;
  assign s2_adv     = s2_valid_q && out_free;
  assign s1_ready_o = !s2_valid_q || out_free;
  assign s1_take    = s1_i.valid && s1_ready_o;

  // best of each group of four bins, lowest index on ties
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_idx_d[g] = KEY_W'(4 * g);
      grp_cnt_d[g] = hist_i[4 * g];
      for (int j = 1; j < 4; j++) begin
        if (hist_i[4 * g + j] > grp_cnt_d[g]) begin
          grp_idx_d[g] = KEY_W'(4 * g + j);
          grp_cnt_d[g] = hist_i[4 * g + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s2_valid_q <= s1_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s2_raw_q  <= s1_i.raw;
      grp_idx_q <= grp_idx_d;
      grp_cnt_q <= grp_cnt_d;
      nk_cnt_q  <= hist_i[KEY_BINS-1];
    end
  end

  // final argmax in ascending order, then the report decision
  always_comb begin
    best_idx = grp_idx_q[0];
    best_cnt = grp_cnt_q[0];
    for (int g = 1; g < Groups; g++) begin
      if (grp_cnt_q[g] > best_cnt) begin
        best_idx = grp_idx_q[g];
        best_cnt = grp_cnt_q[g];
      end
    end
    if (nk_cnt_q > best_cnt) begin
      best_idx = NO_KEY;
      best_cnt = nk_cnt_q;
    end
    hit    = (CmpW'(best_cnt) > CmpW'(thresh_i)) && (best_idx != last_q);
    report = hit ? best_idx : NO_KEY;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= NO_KEY;
    end else begin
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
      if (s2_adv && hit) begin
        last_q <= best_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_raw_q  <= s2_raw_q;
      out_key_q  <= report;
      out_char_q <= key_legend_f(report);
    end
  end

  assign res_out.valid     = out_valid_q;
  assign res_out.raw_index = out_raw_q;
  assign res_out.key_index = out_key_q;
  assign res_out.key_ascii = out_char_q;

  // a reported key is always the remembered one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_key_q != NO_KEY) |-> (out_key_q == last_q))
    else $error("reported key differs from last reported");

  // a held group stage keeps its candidates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_free) |=> (s2_valid_q && $stable(grp_idx_q[0]) &&
                                   $stable(nk_cnt_q) && $stable(s2_raw_q)))
    else $error("group stage changed while stalled");

endmodule
`default_nettype wire

FILE: hw/rtl/keypad_majority_debounce_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_majority_debounce_top: 4x4 keypad scanner with majority vote debounce
// Sample window as a chain of cells, running histogram, registered vote.
// ----------------------------------------------------------------------------
//   channel   dir  handshake        payload
//   key_in    in   valid / ready    key_matrix[15:0]
//   res_out   out  valid / ready    raw_index[4:0], key_index[4:0], key_ascii[6:0]
//   cfg       in   cfg_we_i         cfg_wdata_i[2:0] = vote threshold
//
// One item per cycle while res_out is not stalled; a result is offered once its
// item has passed the sample stage, the group argmax stage and the output register.
// The histogram is updated incrementally on accept: add the new index, drop
// the one shifted out of the last cell.
// Reset fills the window with no-key and sets the threshold to 4.
// A stalled output backs up through the two inner stages before key_in.ready drops.
// ----------------------------------------------------------------------------
module keypad_majority_debounce_top
  import kmd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  kmd_in_if.sink                   key_in,
  kmd_out_if.source                res_out,
  input  wire logic                cfg_we_i,
  input  wire logic [THRESH_W-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(WINDOW_LEN + 1);

  logic                s1_valid_q;
  logic [KEY_W-1:0]    s1_raw_q;
  logic                s1_ready;
  logic                accept;
  logic [KEY_W-1:0]    raw_d;
  logic [THRESH_W-1:0] thresh_q;
  logic [KEY_W-1:0]    win [WINDOW_LEN+1];
  logic [CntW-1:0]     hist_q [KEY_BINS];
  logic [CntW-1:0]     hist_d [KEY_BINS];
  kmd_s1_t             s1;

  assign key_in.ready = !s1_valid_q || s1_ready;
  assign accept       = key_in.valid && key_in.ready;

  // lowest set bit wins
  always_comb begin
    raw_d = NO_KEY;
    for (int b = MATRIX_W - 1; b >= 0; b--) begin
      if (key_in.key_matrix[b]) begin
        raw_d = KEY_W'(b);
      end
    end
  end

  assign win[0] = raw_d;

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    kmd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (win[k]),
      .sample_o (win[k+1])
    );
  end

  // add the new index, drop the oldest
  always_comb begin
    hist_d = hist_q;
    if (accept && (raw_d != win[WINDOW_LEN])) begin
      hist_d[raw_d]           = hist_q[raw_d] + CntW'(1);
      hist_d[win[WINDOW_LEN]] = hist_q[win[WINDOW_LEN]] - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < KEY_BINS; b++) begin
        hist_q[b] <= (b == KEY_BINS - 1) ? CntW'(WINDOW_LEN) : '0;
      end
      s1_valid_q <= 1'b0;
      thresh_q   <= THRESH_RST;
    end else begin
      hist_q <= hist_d;
      if (key_in.ready) begin
        s1_valid_q <= key_in.valid;
      end
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_raw_q <= raw_d;
    end
  end

  assign s1.valid = s1_valid_q;
  assign s1.raw   = s1_raw_q;

  kmd_vote #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_vote (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_i       (s1),
    .s1_ready_o (s1_ready),
    .hist_i     (hist_q),
    .thresh_i   (thresh_q),
    .res_out    (res_out)
  );

  // the newest sample is always counted in the histogram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_q[win[1]] != '0)
    else $error("newest window sample missing from histogram");

  // the sample stage holds what it accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (s1_valid_q && s1_raw_q == win[1]))
    else $error("sample stage does not match newest cell");

endmodule
`default_nettype wire

FILE: dv/tb_keypad_majority_debounce_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_majority_debounce_top: self-checking bench for the keypad debounce
// Drives scan snapshots through the key_in channel, predicts raw index,
// debounced key and legend character per scan, and checks every result in
// order. The vote threshold is swept across its whole range between phases.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_keypad_majority_debounce_top;
  import kmd_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned WINDOW        = WINDOW_LEN_DEF;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam string       KEY_LEGEND    = "123n456F789n*0#RN";

  typedef struct packed {
    logic [KEY_W-1:0]  raw;
    logic [KEY_W-1:0]  key;
    logic [CHAR_W-1:0] chr;
  } scan_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [THRESH_W-1:0] cfg_wdata_i;

  kmd_in_if  key_in_bus ();
  kmd_out_if res_bus ();

  keypad_majority_debounce_top #(
    .WINDOW_LEN (WINDOW)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_in      (key_in_bus),
    .res_out     (res_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Debounce state mirror
  logic [KEY_W-1:0]    win_keys [WINDOW];
  int unsigned         win_slot;
  logic [KEY_W-1:0]    last_key;
  logic [THRESH_W-1:0] vote_thresh;

  scan_result_t expected_results [$];
  int unsigned  errors;
  int unsigned  n_scans;
  int unsigned  n_results;
  int unsigned  n_reports;
  int unsigned  n_rearms;
  logic [15:0]  keys_reported;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_req;
  int unsigned stall_cycles;

  function automatic void debounce_reset();
    for (int i = 0; i < WINDOW; i++) begin
      win_keys[i] = NO_KEY;
    end
    win_slot    = 0;
    last_key    = NO_KEY;
    vote_thresh = THRESH_RST;
  endfunction

  function automatic scan_result_t debounce_predict(input logic [MATRIX_W-1:0] matrix);
    scan_result_t     r;
    int unsigned      hist [KEY_BINS];
    int unsigned      best_cnt;
    logic [KEY_W-1:0] best;
    logic [KEY_W-1:0] raw;
    logic [KEY_W-1:0] report;
    raw = NO_KEY;
    for (int b = MATRIX_W - 1; b >= 0; b--) begin
      if (matrix[b]) begin
        raw = KEY_W'(b);
      end
    end
    // the current scan joins the window before the vote
    win_keys[win_slot] = raw;
    win_slot = (win_slot == WINDOW - 1) ? 0 : win_slot + 1;
    for (int i = 0; i < KEY_BINS; i++) begin
      hist[i] = 0;
    end
    for (int i = 0; i < WINDOW; i++) begin
      hist[win_keys[i]]++;
    end
    best_cnt = 0;
    best     = NO_KEY;
    for (int i = 0; i < KEY_BINS; i++) begin
      if (hist[i] > best_cnt) begin
        best_cnt = hist[i];
        best     = KEY_W'(i);
      end
    end
    report = NO_KEY;
    if (best_cnt > vote_thresh && best != last_key) begin
      last_key = best;
      report   = best;
      if (best == NO_KEY) begin
        n_rearms++;
      end else begin
        n_reports++;
        keys_reported[best] = 1'b1;
      end
    end
    r.raw = raw;
    r.key = report;
    r.chr = CHAR_W'(KEY_LEGEND[report]);
    return r;
  endfunction

  // Offer one item, idling first at the current sender rate
  task automatic send_item(input logic [MATRIX_W-1:0] matrix);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      key_in_bus.valid      <= 1'b0;
      key_in_bus.key_matrix <= MATRIX_W'($urandom);
      @(negedge clk_i);
    end
    key_in_bus.valid      <= 1'b1;
    key_in_bus.key_matrix <= matrix;
    do begin
      @(posedge clk_i);
    end while (!key_in_bus.ready);
    expected_results.push_back(debounce_predict(matrix));
    n_scans++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk_i);
    key_in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [THRESH_W-1:0] thr);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    vote_thresh = thr;
    @(posedge clk_i);
  endtask

  // Mostly held keys with random higher bits and the odd bounce; the rest noise
  task automatic run_random(input int unsigned n_items);
    int unsigned          sent;
    int unsigned          key;
    int unsigned          run_len;
    logic [MATRIX_W-1:0]  matrix;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        key     = $urandom_range(16);
        run_len = $urandom_range(1, 10);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(7) == 0) begin
            matrix = MATRIX_W'($urandom);
          end else if (key == NO_KEY) begin
            matrix = '0;
          end else begin
            matrix = (MATRIX_W'($urandom) & (16'hFFFF << (key + 1))) | (16'h1 << key);
          end
          send_item(matrix);
          sent++;
        end
      end else begin
        send_item(MATRIX_W'($urandom));
        sent++;
      end
    end
  endtask

  // Field extremes, a press won on the scan that completes the vote, release re-arm
  task automatic test_directed();
    src_idle_pct = 14;
    snk_idle_pct = 74;
    send_item(16'h0000);
    send_item(16'hFFFF);
    send_item(16'h8000);
    repeat (3) send_item(16'h0001);
    send_item(16'h0003);
    repeat (6) send_item(16'h0000);
    repeat (5) send_item(16'hFFF1);
    drain_results();
  endtask

  task automatic test_sender_light();
    src_idle_pct = 14;
    snk_idle_pct = 74;
    set_threshold(3'd2);
    run_random(130);
    set_threshold(3'd0);
    run_random(60);
  endtask

  // Threshold 6 leaves nothing to report
  task automatic test_receiver_light();
    src_idle_pct = 74;
    snk_idle_pct = 14;
    set_threshold(3'd3);
    run_random(120);
    set_threshold(3'd6);
    run_random(40);
  endtask

  task automatic test_full_rate();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_threshold(3'd7);
    run_random(30);
    set_threshold(3'd1);
    run_random(60);
    drain_results();
    run_random(60);
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe backs up
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_threshold(3'd5);
    hold_req = HOLD_CYCLES;
    repeat (12) send_item(16'h0200);
    repeat (10) send_item(16'h0000);
    repeat (8) send_item(16'hC200);
    drain_results();
  endtask

  // Receiver ready: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    scan_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual raw %0d key %0d",
                 $realtime, res_bus.raw_index, res_bus.key_index);
      end else begin
        want = expected_results.pop_front();
        if (res_bus.raw_index !== want.raw) begin
          report_mismatch("raw_index", want.raw, res_bus.raw_index);
        end
        if (res_bus.key_index !== want.key) begin
          report_mismatch("key_index", want.key, res_bus.key_index);
        end
        if (res_bus.key_ascii !== want.chr) begin
          report_mismatch("key_ascii", want.chr, res_bus.key_ascii);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((key_in_bus.valid && key_in_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("keypad_majority_debounce_top test failed");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    key_in_bus.valid      = 1'b0;
    key_in_bus.key_matrix = '0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    src_idle_pct          = 0;
    snk_idle_pct          = 0;
    hold_req              = 0;
    stall_cycles          = 0;
    errors                = 0;
    n_scans               = 0;
    n_results             = 0;
    n_reports             = 0;
    n_rearms              = 0;
    keys_reported         = '0;
    debounce_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_directed();
    test_sender_light();
    test_receiver_light();
    test_full_rate();
    test_backpressure();
    drain_results();

    $display("Covered %0d scans and %0d results over thresholds 0 to 7 with stalls on both sides",
             n_scans, n_results);
    $display("Debounced %0d presses (key mask %h) and %0d no-key re-arms",
             n_reports, keys_reported, n_rearms);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("keypad_majority_debounce_top test passed");
    end else begin
      $display("keypad_majority_debounce_top test failed");
    end
    $finish;
  end

endmodule
